// File: rtl/ptb_pkg.sv
// ptb_pkg: shared types and constants of the periodic timer bank.
// No dependencies; imported by every other file of the block but ptb_ram.
package ptb_pkg;

    localparam int DATA_W = 32;   // period, elapsed and remaining counts
    localparam int SLOT_W = 5;    // slot fields on the ports
    localparam int USED_W = 6;    // count of slots in use

    // Input operation codes
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_EXPIRE = 2'd2,
        KIND_TICK   = 2'd3
    } t_kind;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_REMOVE,
        ST_TICK_RD,
        ST_TICK_CALC,
        ST_TICK_DONE
    } t_state;

    // Result of the shared compare/subtract unit
    typedef struct packed {
        logic              gt;    // remaining > elapsed
        logic [DATA_W-1:0] diff;  // remaining - elapsed
    } t_alu_res;

endpackage

// File: rtl/ptb_if.sv
// ptb_in_if / ptb_out_if: valid/ready channels of the periodic timer bank.
// Depends on ptb_pkg for field widths.
interface ptb_in_if import ptb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [DATA_W-1:0] period;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] elapsed;

    modport source (output valid, output op, output period, output slot,
                    output elapsed, input ready);
    modport sink   (input valid, input op, input period, input slot,
                    input elapsed, output ready);
endinterface

interface ptb_out_if import ptb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot_index;
    logic              error;
    logic              last;

    modport source (output valid, output kind, output slot_index,
                    output error, output last, input ready);
    modport sink   (input valid, input kind, input slot_index,
                    input error, input last, output ready);
endinterface

// File: rtl/ptb_ram.sv
// ptb_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module ptb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, holds while idle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/ptb_alu.sv
// ptb_alu: shared compare/subtract unit used once per in-use slot on a tick.
// Depends on ptb_pkg for t_alu_res.
module ptb_alu import ptb_pkg::*; (
    input  logic [DATA_W-1:0] i_remaining,
    input  logic [DATA_W-1:0] i_elapsed,
    output t_alu_res          o_res
);

    logic [DATA_W:0] sub;

    // one wide subtract; the borrow gives the compare
    assign sub        = {1'b0, i_remaining} - {1'b0, i_elapsed};
    assign o_res.diff = sub[DATA_W-1:0];
    assign o_res.gt   = !sub[DATA_W] && (sub[DATA_W-1:0] != '0);

endmodule

// File: rtl/periodic_timer_bank.sv
// periodic_timer_bank: top level, sequencer, slot table and result register.
// Depends on ptb_pkg, ptb_if, ptb_ram and ptb_alu.
//
//  channel | dir | words                               | fields
//  i_cmd   | in  | one per operation                   | op, period, slot, elapsed
//  o_evt   | out | one per add/remove, 1+expiries/tick | kind, slot_index, error, last
//
// Add: scans from slot 0 past occupied slots to the first free one; full: error.
// Tick: walks every slot, with a read state and a calc state per in-use slot; the
// single read port of the count RAM and the shared subtractor set the pace.
// Reset clears the in-use flags and count; the count RAMs need no clearing.
// A stalled o_evt holds the sequencer before it posts the next word.
module periodic_timer_bank import ptb_pkg::*; #(
    parameter int TIMERS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ptb_in_if.sink   i_cmd,
    ptb_out_if.source o_evt
);

    localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_W = $clog2(TIMERS + 1);
    localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(TIMERS);
    localparam logic [USED_W-1:0] FULL_CNT = USED_W'(TIMERS);
    localparam logic [SLOT_W:0]   SLOT_LIM = (SLOT_W + 1)'(TIMERS);

    t_state            r_state, n_state;
    logic [DATA_W-1:0] r_period;
    logic [SLOT_W-1:0] r_slot;
    logic [DATA_W-1:0] r_elapsed;
    logic [CNT_W-1:0]  r_idx;
    logic [TIMERS-1:0] r_in_use;
    logic [USED_W-1:0] r_used;

    logic              r_out_valid;
    t_kind             r_kind;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_err;
    logic              r_out_last;

    logic              accept;
    logic              out_free;
    logic              full;
    logic [IDX_W-1:0]  idx_a;
    logic [IDX_W-1:0]  rm_idx;
    logic              cur_used;
    logic              rm_hit;

    logic              in_ready;
    logic              rd_en;
    logic              rem_wr_en;
    logic              rel_wr_en;
    logic [DATA_W-1:0] rem_wr_data;
    logic              out_load;
    t_kind             out_kind;
    logic [SLOT_W-1:0] out_slot;
    logic              out_err;
    logic              out_last;
    logic              set_use;
    logic              clr_use;
    logic              idx_inc;

    logic [DATA_W-1:0] rem_q;
    logic [DATA_W-1:0] rel_q;
    t_alu_res          alu_res;

    assign accept   = i_cmd.valid && in_ready;
    assign out_free = !r_out_valid || o_evt.ready;
    assign full     = (r_used == FULL_CNT);
    assign idx_a    = r_idx[IDX_W-1:0];
    assign rm_idx   = IDX_W'(r_slot);
    assign cur_used = r_in_use[idx_a];
    assign rm_hit   = ({1'b0, r_slot} < SLOT_LIM) && r_in_use[rm_idx];

    // count and reload stores
    ptb_ram #(.WIDTH(DATA_W), .DEPTH(TIMERS)) u_rem_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rem_wr_en),
        .i_wr_addr (idx_a),
        .i_wr_data (rem_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (idx_a),
        .o_rd_data (rem_q)
    );

    ptb_ram #(.WIDTH(DATA_W), .DEPTH(TIMERS)) u_rel_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rel_wr_en),
        .i_wr_addr (idx_a),
        .i_wr_data (r_period),
        .i_rd_en   (rd_en),
        .i_rd_addr (idx_a),
        .o_rd_data (rel_q)
    );

    ptb_alu u_alu (
        .i_remaining (rem_q),
        .i_elapsed   (r_elapsed),
        .o_res       (alu_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.op)
                        OP_ADD:    n_state = ST_ADD;
                        OP_REMOVE: n_state = ST_REMOVE;
                        OP_TICK:   n_state = ST_TICK_RD;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                if ((full || !cur_used) && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_REMOVE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TICK_RD: begin
                if (r_idx == LAST_CNT) begin
                    n_state = ST_TICK_DONE;
                end else if (cur_used) begin
                    n_state = ST_TICK_CALC;
                end
            end
            ST_TICK_CALC: begin
                if (alu_res.gt || out_free) begin
                    n_state = ST_TICK_RD;
                end
            end
            ST_TICK_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready    = 1'b0;
        rd_en       = 1'b0;
        rem_wr_en   = 1'b0;
        rel_wr_en   = 1'b0;
        rem_wr_data = r_period;
        out_load    = 1'b0;
        out_kind    = KIND_TICK;
        out_slot    = '0;
        out_err     = 1'b0;
        out_last    = 1'b1;
        set_use     = 1'b0;
        clr_use     = 1'b0;
        idx_inc     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_ADD: begin
                out_kind = KIND_ADD;
                if (full) begin
                    out_load = out_free;
                    out_err  = 1'b1;
                end else if (!cur_used) begin
                    out_load  = out_free;
                    out_slot  = SLOT_W'(idx_a);
                    set_use   = out_free;
                    rem_wr_en = out_free;
                    rel_wr_en = out_free;
                end else begin
                    idx_inc = 1'b1;
                end
            end
            ST_REMOVE: begin
                out_kind = KIND_REMOVE;
                out_slot = r_slot;
                out_err  = !rm_hit;
                out_load = out_free;
                clr_use  = out_free && rm_hit;
            end
            ST_TICK_RD: begin
                if (r_idx != LAST_CNT) begin
                    if (cur_used) begin
                        rd_en = 1'b1;
                    end else begin
                        idx_inc = 1'b1;
                    end
                end
            end
            ST_TICK_CALC: begin
                out_kind = KIND_EXPIRE;
                out_slot = SLOT_W'(idx_a);
                out_last = 1'b0;
                if (alu_res.gt) begin
                    rem_wr_data = alu_res.diff;
                    rem_wr_en   = 1'b1;
                    idx_inc     = 1'b1;
                end else begin
                    rem_wr_data = rel_q;
                    rem_wr_en   = out_free;
                    out_load    = out_free;
                    idx_inc     = out_free;
                end
            end
            ST_TICK_DONE: begin
                out_load = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_in_use <= '0;
            r_used   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_idx <= '0;
            end else if (idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (set_use) begin
                r_in_use[idx_a] <= 1'b1;
                r_used          <= r_used + 1'b1;
            end else if (clr_use) begin
                r_in_use[rm_idx] <= 1'b0;
                r_used           <= r_used - 1'b1;
            end
        end
    end

    // command word capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_period  <= i_cmd.period;
            r_slot    <= i_cmd.slot;
            r_elapsed <= i_cmd.elapsed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_kind     <= out_kind;
            r_out_slot <= out_slot;
            r_out_err  <= out_err;
            r_out_last <= out_last;
        end
    end

    assign i_cmd.ready      = in_ready;
    assign o_evt.valid      = r_out_valid;
    assign o_evt.kind       = r_kind;
    assign o_evt.slot_index = r_out_slot;
    assign o_evt.error      = r_out_err;
    assign o_evt.last       = r_out_last;

endmodule

// File: rtl/ptb_checker.sv
// ptb_checker: port-level assertions for periodic_timer_bank, and its bind.
// Depends on ptb_pkg for operation codes and result kinds.
module ptb_checker import ptb_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [1:0]        i_in_op,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [1:0]        i_out_kind,
    input logic [SLOT_W-1:0] i_out_slot,
    input logic              i_out_error,
    input logic              i_out_last
);

    // a real operation word drops ready in the cycle after it is taken
    a_busy_after_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready
         && ((i_in_op == OP_TICK) || (i_in_op == OP_ADD) || (i_in_op == OP_REMOVE)))
        |=> !i_in_ready)
        else $error("ptb: ready stayed high after an operation word");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_out_kind) && $stable(i_out_slot)
             && $stable(i_out_error) && $stable(i_out_last)))
        else $error("ptb: stalled result word changed");

    // tick done closes the tick with slot 0 and no error
    a_tick_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind == KIND_TICK))
        |-> (i_out_last && !i_out_error && (i_out_slot == '0)))
        else $error("ptb: malformed tick done word");

    // expiries never close an operation and never carry an error
    a_expire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind == KIND_EXPIRE))
        |-> (!i_out_last && !i_out_error))
        else $error("ptb: malformed expiry word");

    // add and remove answer with one closing word
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && ((i_out_kind == KIND_ADD) || (i_out_kind == KIND_REMOVE)))
        |-> i_out_last)
        else $error("ptb: add/remove word without last");

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_in_op     (i_cmd.op),
    .i_out_valid (o_evt.valid),
    .i_out_ready (o_evt.ready),
    .i_out_kind  (o_evt.kind),
    .i_out_slot  (o_evt.slot_index),
    .i_out_error (o_evt.error),
    .i_out_last  (o_evt.last)
);

// File: tb/tb_periodic_timer_bank.sv
// tb_periodic_timer_bank: self-checking bench for the periodic timer bank.
// Depends on ptb_pkg, ptb_if and the block's RTL. Directed words come first,
// then random bursts; a tracker predicts every result word and checks it.

import ptb_pkg::*;

// One expected result word
typedef struct {
    t_kind             kind;
    logic [SLOT_W-1:0] slot_index;
    logic              error;
    logic              last;
} t_evt_word;

// Tracks the timer table and the result words still owed by the block
class timer_table_tracker #(int SLOTS = 32);
    logic [DATA_W-1:0] count_left [SLOTS];
    logic [DATA_W-1:0] period_of  [SLOTS];
    bit                busy       [SLOTS];
    int                busy_count;
    t_evt_word         pending_events [$];
    int                mismatches;

    function new();
        foreach (busy[i]) busy[i] = 1'b0;
        busy_count = 0;
        mismatches = 0;
    endfunction

    function void queue_word(t_kind kind, int idx, logic err, logic last);
        t_evt_word w;
        w.kind       = kind;
        w.slot_index = idx[SLOT_W-1:0];
        w.error      = err;
        w.last       = last;
        pending_events.push_back(w);
    endfunction

    // Update the table for an accepted command word and queue its results
    function void log_command(logic [1:0] op, logic [DATA_W-1:0] period,
                              logic [SLOT_W-1:0] slot, logic [DATA_W-1:0] elapsed);
        bit placed;
        placed = 1'b0;
        case (op)
            OP_ADD: begin
                // lowest free slot wins
                for (int i = 0; i < SLOTS && !placed; i++) begin
                    if (!busy[i]) begin
                        busy[i]       = 1'b1;
                        count_left[i] = period;
                        period_of[i]  = period;
                        busy_count++;
                        queue_word(KIND_ADD, i, 1'b0, 1'b1);
                        placed = 1'b1;
                    end
                end
                if (!placed) queue_word(KIND_ADD, 0, 1'b1, 1'b1);
            end
            OP_REMOVE: begin
                if (slot < SLOTS && busy[slot]) begin
                    busy[slot] = 1'b0;
                    busy_count--;
                    queue_word(KIND_REMOVE, slot, 1'b0, 1'b1);
                end else begin
                    queue_word(KIND_REMOVE, slot, 1'b1, 1'b1);
                end
            end
            OP_TICK: begin
                // walk in-use slots in ascending order
                for (int i = 0; i < SLOTS; i++) begin
                    if (busy[i]) begin
                        if (count_left[i] > elapsed) begin
                            count_left[i] = count_left[i] - elapsed;
                        end else begin
                            count_left[i] = period_of[i];
                            queue_word(KIND_EXPIRE, i, 1'b0, 1'b0);
                        end
                    end
                end
                queue_word(KIND_TICK, 0, 1'b0, 1'b1);
            end
            default: ; // unused op: no result, no state change
        endcase
    endfunction

    function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
            mismatches++;
        end
    endfunction

    // Check one accepted result word against the oldest expectation
    function void check_event(logic [1:0] kind, logic [SLOT_W-1:0] idx,
                              logic err, logic last);
        t_evt_word want;
        if (pending_events.size() == 0) begin
            $display("%0t: unexpected word, expected none actual kind=%0d slot=%0d err=%0d last=%0d",
                     $time, kind, idx, err, last);
            mismatches++;
            return;
        end
        want = pending_events.pop_front();
        compare_field("kind", 32'(want.kind), 32'(kind));
        compare_field("slot_index", 32'(want.slot_index), 32'(idx));
        compare_field("error", 32'(want.error), 32'(err));
        compare_field("last", 32'(want.last), 32'(last));
    endfunction

    // Random in-use slot, or any slot when the table is empty
    function logic [SLOT_W-1:0] pick_busy_slot();
        int taken [$];
        for (int i = 0; i < SLOTS; i++) if (busy[i]) taken.push_back(i);
        if (taken.size() == 0) return SLOT_W'($urandom_range(0, SLOTS - 1));
        return SLOT_W'(taken[$urandom_range(0, taken.size() - 1)]);
    endfunction
endclass

module tb_periodic_timer_bank;

    localparam int         SLOTS        = 32;
    localparam int         RAND_ITEMS   = 380;
    localparam int         BURST_LEN    = 30;
    localparam int         STALL_LIMIT  = 4000;
    localparam int         DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int         HOLD_TRIGGER = 40;
    localparam int         HOLD_CYCLES  = 600;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_FILL, MODE_MIX} t_burst;

    logic clk;
    logic rst_n;
    bit   calm;          // no sender gaps and no new random sink stalls while set
    int   cmds_taken;
    int   items_done;

    timer_table_tracker #(SLOTS) book;

    ptb_in_if  cmd_if ();
    ptb_out_if evt_if ();

    periodic_timer_bank #(.TIMERS(SLOTS)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_evt   (evt_if)
    );

    // 10-unit clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sender gap: mostly none or short, sometimes long
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Periods: mostly small so timers expire often
    function automatic logic [DATA_W-1:0] rand_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 15);
        if (r < 75) return $urandom_range(16, 200);
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return 1;
                2: return ALL_ONES - 1;
                default: return ALL_ONES;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [DATA_W-1:0] rand_elapsed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 6);
        if (r < 75) return $urandom_range(7, 50);
        if (r < 85) return ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
        return $urandom;
    endfunction

    // Offer one command word and wait until it is taken
    task automatic send_cmd(input logic [1:0] op, input logic [DATA_W-1:0] period,
                            input logic [SLOT_W-1:0] slot,
                            input logic [DATA_W-1:0] elapsed);
        int gap;
        gap = rand_gap();
        if (gap > 0) begin
            @(negedge clk);
            cmd_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_if.valid   <= 1'b1;
        cmd_if.op      <= op;
        cmd_if.period  <= period;
        cmd_if.slot    <= slot;
        cmd_if.elapsed <= elapsed;
        @(posedge clk);
        while (cmd_if.ready !== 1'b1) @(posedge clk);
        book.log_command(op, period, slot, elapsed);
        cmds_taken++;
        if (op != OP_UNUSED) items_done++;
    endtask

    // Result sink: random stalls, plus one long hold-off to back up the block
    initial begin : evt_drain
        int  hold;
        int  r;
        bit  pressed;
        hold    = 0;
        pressed = 1'b0;
        evt_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (!pressed && cmds_taken >= HOLD_TRIGGER) begin
                pressed = 1'b1;
                hold    = HOLD_CYCLES;
            end else if (hold == 0 && !calm && $urandom_range(0, 99) < 20) begin
                r    = $urandom_range(0, 99);
                hold = (r < 85) ? $urandom_range(1, 3) : $urandom_range(15, 60);
            end
            if (hold > 0) begin
                evt_if.ready <= 1'b0;
                hold--;
            end else begin
                evt_if.ready <= 1'b1;
            end
        end
    end

    // Check every result word taken by the sink
    always @(posedge clk) begin
        if (rst_n === 1'b1 && evt_if.valid === 1'b1 && evt_if.ready === 1'b1) begin
            book.check_event(evt_if.kind, evt_if.slot_index, evt_if.error, evt_if.last);
        end
    end

    // Watchdog: ends the run if neither channel moves for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (cmd_if.valid && cmd_if.ready) || (evt_if.valid && evt_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("tb_periodic_timer_bank NOT OK");
        $finish;
    end

    // Main stimulus
    initial begin : stimulus
        t_burst mode;
        int     start_items;
        int     r;
        int     add_pct;
        int     rem_pct;
        int     burst_no;
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;

        book           = new();
        calm           = 1'b0;
        cmds_taken     = 0;
        items_done     = 0;
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.op      = OP_TICK;
        cmd_if.period  = '0;
        cmd_if.slot    = '0;
        cmd_if.elapsed = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty tick, removes of free slots, period and elapsed extremes
        send_cmd(OP_TICK,   '0,       '0,  32'd5);
        send_cmd(OP_REMOVE, '0,       5'd0,  '0);
        send_cmd(OP_REMOVE, '0,       5'd31, '0);
        send_cmd(OP_ADD,    '0,       '0,  '0);      // zero period: expires every tick
        send_cmd(OP_ADD,    ALL_ONES, '0,  '0);
        send_cmd(OP_ADD,    32'd1,    '0,  '0);
        send_cmd(OP_ADD,    32'd3,    '0,  '0);
        send_cmd(OP_TICK,   '0,       '0,  '0);      // zero elapsed
        send_cmd(OP_TICK,   '0,       '0,  32'd1);
        send_cmd(OP_TICK,   '0,       '0,  ALL_ONES);
        send_cmd(OP_REMOVE, '0,       5'd1,  '0);
        send_cmd(OP_REMOVE, '0,       5'd1,  '0);    // already free
        send_cmd(OP_ADD,    32'd7,    '0,  '0);      // reuses the lowest hole
        send_cmd(OP_UNUSED, ALL_ONES, 5'd31, ALL_ONES);
        send_cmd(OP_TICK,   '0,       '0,  32'd2);
        send_cmd(OP_REMOVE, '0,       5'd0,  '0);
        send_cmd(OP_REMOVE, '0,       5'd2,  '0);
        send_cmd(OP_REMOVE, '0,       5'd3,  '0);
        send_cmd(OP_REMOVE, '0,       5'd1,  '0);
        send_cmd(OP_TICK,   '0,       '0,  '0);

        // Random bursts; the first one always fills the table
        start_items = items_done;
        burst_no    = 0;
        while (items_done - start_items < RAND_ITEMS) begin
            mode = (burst_no == 0) ? MODE_FILL : t_burst'($urandom_range(0, 3));
            calm = ($urandom_range(0, 4) == 0);
            burst_no++;
            case (mode)
                MODE_GROW:   begin add_pct = 55; rem_pct = 10; end
                MODE_SHRINK: begin add_pct = 15; rem_pct = 50; end
                default:     begin add_pct = 30; rem_pct = 30; end
            endcase
            if (mode == MODE_FILL) begin
                while (book.busy_count < SLOTS)
                    send_cmd(OP_ADD, rand_period(), SLOT_W'($urandom), $urandom);
                repeat (2)
                    send_cmd(OP_ADD, rand_period(), SLOT_W'($urandom), $urandom); // full
            end
            for (int k = 0; k < BURST_LEN; k++) begin
                r = $urandom_range(0, 99);
                if (r < 3)                       op = OP_UNUSED;
                else if (r < 3 + add_pct)        op = OP_ADD;
                else if (r < 3 + add_pct + rem_pct) op = OP_REMOVE;
                else                             op = OP_TICK;
                if (op == OP_REMOVE && $urandom_range(0, 9) < 8)
                    slot = book.pick_busy_slot();
                else
                    slot = SLOT_W'($urandom);
                send_cmd(op, rand_period(), slot, rand_elapsed());
            end
        end

        // Drain and settle
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        calm = 1'b1;
        while (book.pending_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.mismatches == 0 && book.pending_events.size() == 0)
            $display("tb_periodic_timer_bank OK");
        else
            $display("tb_periodic_timer_bank NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ptb_pkg.sv
rtl/ptb_if.sv
rtl/ptb_ram.sv
rtl/ptb_alu.sv
rtl/periodic_timer_bank.sv
rtl/ptb_checker.sv
tb/tb_periodic_timer_bank.sv
